// File: src/serial_can_frame_deframer_top_assert.svh
// Assertion macros shared by the deframer checker.
`ifndef SERIAL_CAN_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define SERIAL_CAN_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Check a property while out of reset.
`define SCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/scd_pkg.sv
// Types and constants of the serial CAN frame deframer.
package scd_pkg;

  localparam logic [7:0] START_BYTE        = 8'hAA;
  localparam logic [7:0] END_BYTE          = 8'hBB;
  localparam logic [4:0] LENGTH_POS        = 5'd4;
  localparam logic [4:0] ID_FIRST_POS      = 5'd5;
  localparam logic [4:0] PAYLOAD_FIRST_POS = 5'd9;
  localparam int         MAX_PAYLOAD       = 8;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_END = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

  localparam int RESULT_BITS = 102;
  localparam int TDATA_BITS  = 104;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_stage_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [31:0] can_id;
    logic [3:0]  payload_length;
    logic [63:0] payload_bytes;
  } result_t;

  typedef struct packed {
    logic    load;
    result_t res;
  } result_load_t;

endpackage

// File: src/serial_can_frame_deframer_top.sv
// Top level of the serial CAN frame deframer.
//
//  channel | dir | payload
//  in_     | in  | tdata[7:0] rx_byte
//  out_    | out | tdata[103:0] frame_status, can_id, payload_length, payload_bytes
//
// One byte per cycle is accepted while in_tready is high; each byte is parsed in
// a single pass between the input register and the result register, so a result
// is loaded into the result register as the byte that ends its frame is taken.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to idle.
// in_tready drops only while a frame-ending byte waits in the input register
// and the result register holds an untaken result.
module serial_can_frame_deframer_top #(
  parameter int MAX_PAYLOAD = scd_pkg::MAX_PAYLOAD
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] rx_byte
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [103:0]  out_tdata   // [1:0] frame_status, [33:2] can_id,
                                    // [37:34] payload_length, [101:38] payload_bytes
);

  scd_pkg::byte_stage_t  stage;
  scd_pkg::result_load_t result;
  logic                  take;
  logic                  room;

  scd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (take),
    .stage     (stage)
  );

  scd_assembler #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_assembler (
    .clk    (clk),
    .rst_n  (rst_n),
    .stage  (stage),
    .room   (room),
    .take   (take),
    .result (result)
  );

  scd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .result     (result),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: src/scd_in_reg.sv
// Input register stage for received serial bytes.
module scd_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               take,
  output scd_pkg::byte_stage_t stage
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       load;

  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_tdata;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule

// File: src/scd_assembler.sv
// Frame parser: tracks position, collects identifier and payload, builds results.
module scd_assembler #(
  parameter int MAX_PAYLOAD = scd_pkg::MAX_PAYLOAD
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scd_pkg::byte_stage_t  stage,
  input  logic                  room,
  output logic                  take,
  output scd_pkg::result_load_t result
);

  logic        recv_r, recv_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [31:0] id_r, id_nxt;
  logic [63:0] pay_r, pay_nxt;

  logic        produces;
  scd_pkg::result_t res;
  logic [7:0]  b;
  logic [3:0]  len_eff;
  logic [4:0]  end_pos;
  logic [4:0]  k;

  assign b = stage.data;

  always_comb begin
    recv_nxt = recv_r;
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    id_nxt   = id_r;
    pay_nxt  = pay_r;
    produces = 1'b0;
    res      = '0;
    len_eff  = (pos_r == scd_pkg::LENGTH_POS) ? b[3:0] : len_r;
    end_pos  = scd_pkg::PAYLOAD_FIRST_POS + {1'b0, len_eff};
    k        = pos_r - scd_pkg::PAYLOAD_FIRST_POS;
    if (!recv_r) begin
      if (b == scd_pkg::START_BYTE) begin
        recv_nxt = 1'b1;
        pos_nxt  = '0;
        len_nxt  = '0;
        id_nxt   = '0;
        pay_nxt  = '0;
      end
    end else if (pos_r == scd_pkg::LENGTH_POS && b > 8'(MAX_PAYLOAD)) begin
      // oversize length: end the frame here with everything zeroed
      produces         = 1'b1;
      res.frame_status = scd_pkg::STATUS_BAD_LEN;
      recv_nxt         = 1'b0;
      pos_nxt          = '0;
      len_nxt          = '0;
    end else if (pos_r < end_pos) begin
      len_nxt = len_eff;
      if (pos_r >= scd_pkg::ID_FIRST_POS && pos_r < scd_pkg::PAYLOAD_FIRST_POS) begin
        id_nxt = {b, id_r[31:8]};
      end else if (pos_r >= scd_pkg::PAYLOAD_FIRST_POS) begin
        pay_nxt[8*k[2:0] +: 8] = pay_r[8*k[2:0] +: 8] | b;
      end
      pos_nxt = pos_r + 5'd1;
    end else begin
      produces           = 1'b1;
      res.frame_status   = (b == scd_pkg::END_BYTE) ? scd_pkg::STATUS_OK
                                                    : scd_pkg::STATUS_BAD_END;
      res.can_id         = id_r;
      res.payload_length = len_r;
      res.payload_bytes  = pay_r;
      recv_nxt           = 1'b0;
      pos_nxt            = '0;
      len_nxt            = '0;
    end
  end

  // hold a frame-ending byte while the result register is still occupied
  assign take        = stage.valid && (!produces || room);
  assign result.load = take && produces;
  assign result.res  = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recv_r <= 1'b0;
      pos_r  <= '0;
      len_r  <= '0;
    end else if (take) begin
      recv_r <= recv_nxt;
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      id_r  <= id_nxt;
      pay_r <= pay_nxt;
    end
  end

endmodule

// File: src/scd_out_reg.sv
// Result register driving the output stream.
module scd_out_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  scd_pkg::result_load_t           result,
  output logic                            room,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [scd_pkg::TDATA_BITS-1:0]  out_tdata
);

  logic             valid_r, valid_nxt;
  scd_pkg::result_t res_r;

  assign room = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (result.load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      res_r <= result.res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {(scd_pkg::TDATA_BITS - scd_pkg::RESULT_BITS)'(0),
                       res_r.payload_bytes, res_r.payload_length,
                       res_r.can_id, res_r.frame_status};

endmodule

// File: src/scd_checker.sv
// Port-level checker for the deframer, bound to the top level.
`include "serial_can_frame_deframer_top_assert.svh"

module scd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  logic [1:0]  st;
  logic [3:0]  plen;
  logic [99:0] body;
  logic        stalled;
  logic        fields_ok;
  logic        len_err;

  assign st        = out_tdata[1:0];
  assign plen      = out_tdata[37:34];
  assign body      = out_tdata[101:2];
  assign stalled   = out_tvalid && !out_tready;
  assign fields_ok = (st <= scd_pkg::STATUS_BAD_LEN) && (plen <= 4'(scd_pkg::MAX_PAYLOAD));
  assign len_err   = out_tvalid && (st == scd_pkg::STATUS_BAD_LEN);

  `SCD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")
  `SCD_ASSERT(a_hold, clk, rst_n, stalled |=> out_tvalid && $stable(out_tdata), "result moved")
  `SCD_ASSERT(a_range, clk, rst_n, out_tvalid |-> fields_ok, "status or length out of range")
  `SCD_ASSERT(a_len_err_zero, clk, rst_n, len_err |-> body == '0, "length error not cleared")
  `SCD_ASSERT(a_in_ready, clk, rst_n, !out_tvalid |-> in_tready, "input stalled without cause")

endmodule

bind serial_can_frame_deframer_top scd_checker u_scd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: sim/tb_top.sv
// Testbench for the serial CAN frame deframer: byte stimulus, frame prediction and result checks.
module tb_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 10;
  localparam int BYTES_PER_PHASE = 150;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_request  = 0;
  int hold_count    = 0;
  int idle_cycles   = 0;

  serial_can_frame_deframer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Tracks the frame parser and holds the frames it has finished but not yet seen leave.
  class frame_scoreboard;
    bit                frame_open;
    bit [4:0]          position;
    bit [3:0]          frame_len;
    bit [31:0]         id_acc;
    bit [63:0]         data_acc;
    scd_pkg::result_t  frame_q[$];
    int                n_bytes;
    int                n_errors;
    int                n_ok;
    int                n_bad_end;
    int                n_bad_len;

    function void clear_frame();
      frame_open = 1'b0;
      position   = '0;
      frame_len  = '0;
      id_acc     = '0;
      data_acc   = '0;
    endfunction

    function int pending();
      return frame_q.size();
    endfunction

    function void note_byte(logic [7:0] b);
      scd_pkg::result_t fin;
      int               k;
      n_bytes++;
      if (!frame_open) begin
        if (b == scd_pkg::START_BYTE) begin
          clear_frame();
          frame_open = 1'b1;
        end
        return;
      end
      if (position == scd_pkg::LENGTH_POS) begin
        if (int'(b) > scd_pkg::MAX_PAYLOAD) begin
          fin = '{frame_status: scd_pkg::STATUS_BAD_LEN, can_id: '0, payload_length: '0,
                  payload_bytes: '0};
          frame_q.push_back(fin);
          clear_frame();
          return;
        end
        frame_len = b[3:0];
      end
      if (int'(position) < int'(scd_pkg::PAYLOAD_FIRST_POS) + int'(frame_len)) begin
        if (position >= scd_pkg::ID_FIRST_POS && position < scd_pkg::PAYLOAD_FIRST_POS) begin
          id_acc = {b, id_acc[31:8]};
        end else if (position >= scd_pkg::PAYLOAD_FIRST_POS) begin
          k = int'(position) - int'(scd_pkg::PAYLOAD_FIRST_POS);
          data_acc[8*k +: 8] = b;
        end
        position = position + 5'd1;
        return;
      end
      // byte after the payload closes the frame either way
      fin.frame_status   = (b == scd_pkg::END_BYTE) ? scd_pkg::STATUS_OK
                                                    : scd_pkg::STATUS_BAD_END;
      fin.can_id         = id_acc;
      fin.payload_length = frame_len;
      fin.payload_bytes  = data_acc;
      frame_q.push_back(fin);
      clear_frame();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(logic [103:0] t);
      scd_pkg::result_t want;
      if (frame_q.size() == 0) begin
        $display("%0t: frame result expected none actual %h", $time, t);
        n_errors++;
        return;
      end
      want = frame_q.pop_front();
      compare_field("frame_status", 64'(want.frame_status), 64'(t[1:0]));
      compare_field("can_id", 64'(want.can_id), 64'(t[33:2]));
      compare_field("payload_length", 64'(want.payload_length), 64'(t[37:34]));
      compare_field("payload_bytes", want.payload_bytes, t[101:38]);
      if (want.frame_status == scd_pkg::STATUS_OK) n_ok++;
      else if (want.frame_status == scd_pkg::STATUS_BAD_END) n_bad_end++;
      else n_bad_len++;
    endfunction
  endclass

  frame_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sample both channels before the edge updates the block.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tdata);
    if (rst_n && out_tvalid === 1'b1 && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid === 1'b1 && out_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d frames outstanding",
                 $time, idle_cycles, sb.pending());
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_count   = hold_request;
      hold_request = 0;
    end
    if (hold_count > 0) begin
      hold_count = hold_count - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  // Length byte above the maximum stops the frame right after it.
  task automatic send_frame(input logic [31:0] stamp, input logic [7:0] len_byte,
                            input logic [31:0] id, input logic [63:0] data,
                            input logic [7:0] end_byte);
    send_byte(scd_pkg::START_BYTE);
    for (int i = 0; i < 4; i++) send_byte(stamp[8*i +: 8]);
    send_byte(len_byte);
    if (int'(len_byte) > scd_pkg::MAX_PAYLOAD) return;
    for (int i = 0; i < 4; i++) send_byte(id[8*i +: 8]);
    for (int i = 0; i < int'(len_byte); i++) send_byte(data[8*i +: 8]);
    send_byte(end_byte);
  endtask

  task automatic send_random_frame();
    logic [7:0] len_byte;
    logic [7:0] end_byte;
    int         pick;
    pick     = $urandom_range(99);
    len_byte = 8'($urandom_range(scd_pkg::MAX_PAYLOAD));
    end_byte = scd_pkg::END_BYTE;
    if (pick < 65) begin
      end_byte = scd_pkg::END_BYTE;
    end else if (pick < 77) begin
      do end_byte = 8'($urandom_range(255)); while (end_byte == scd_pkg::END_BYTE);
    end else if (pick < 87) begin
      len_byte = 8'($urandom_range(255, scd_pkg::MAX_PAYLOAD + 1));
    end else begin
      // line noise between frames, may itself open a broken frame
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      return;
    end
    send_frame($urandom(), len_byte, $urandom(), {$urandom(), $urandom()}, end_byte);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int phase_start;
    int idle_mix[4][2];
    idle_mix = '{'{0, 0}, '{60, 0}, '{0, 60}, '{30, 30}};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct   = idle_mix[ph][0];
      out_stall_pct = idle_mix[ph][1];
      phase_start   = sb.n_bytes;
      if (ph == 0) begin
        // idle bytes, shortest and longest length, bad lengths, bad end, start byte inside
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(scd_pkg::END_BYTE);
        send_frame(32'h0, 8'd9, 32'h0, 64'h0, scd_pkg::END_BYTE);
        send_frame(32'hFFFF_FFFF, 8'hFF, 32'h0, 64'h0, scd_pkg::END_BYTE);
        send_frame({4{scd_pkg::START_BYTE}}, 8'd0, 32'hFFFF_FFFF, 64'h0, scd_pkg::END_BYTE);
        send_frame(32'h0, 8'd8, {scd_pkg::START_BYTE, 24'h00_AA_00}, 64'hFFFF_FFFF_FFFF_FFFF,
                   scd_pkg::END_BYTE);
        send_frame(32'h1234_5678, 8'd1, 32'h0000_0000, {56'h0, scd_pkg::START_BYTE},
                   scd_pkg::START_BYTE);
        send_byte(8'h5A);
        drain_results();

        // hold the result side while short frames keep coming, so the input backs up
        hold_request = HOLD_CYCLES;
        repeat (12) send_frame($urandom(), 8'($urandom_range(255, scd_pkg::MAX_PAYLOAD + 1)),
                               32'h0, 64'h0, scd_pkg::END_BYTE);
        drain_results();
      end
      while (sb.n_bytes - phase_start < BYTES_PER_PHASE) send_random_frame();
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("summary: %0d bytes in four idle/stall mixes", sb.n_bytes);
    $display("frames: %0d ok, %0d bad end, %0d bad length",
             sb.n_ok, sb.n_bad_end, sb.n_bad_len);
    if (sb.n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
